// ===== rtl/core/a32icd_pkg.sv =====
// ----------------------------------------------------------------------------
// a32icd_pkg
// Shared types and codes for the A32 instruction class decoder: handler
// classes, instruction group labels and the per-item decode verdict.
// ----------------------------------------------------------------------------
`default_nettype none

package a32icd_pkg;

  localparam int unsigned InstrWidth  = 32;
  localparam int unsigned OutTdataW   = 16;

  typedef enum logic [3:0] {
    C_OTHERS      = 4'd0,
    C_PRELOAD     = 4'd1,
    C_PRELOAD_REG = 4'd2,
    C_UNPRED      = 4'd3,
    C_UNDEF       = 4'd4,
    C_BRANCH      = 4'd5,
    C_COPRO_LS    = 4'd6,
    C_ALU_IMM     = 4'd7,
    C_ALU_REG     = 4'd8,
    C_ALU_SREG    = 4'd9,
    C_BX_REG      = 4'd10,
    C_EXTRA_LS    = 4'd11,
    C_LDST        = 4'd12,
    C_BLOCK       = 4'd13,
    C_SVC         = 4'd14,
    C_NONE        = 4'd15
  } hclass_t;

  typedef enum logic [5:0] {
    G_NIL          = 6'd0,
    G_CPS          = 6'd1,
    G_SETEND       = 6'd2,
    G_NEON_DP      = 6'd3,
    G_NEON_LS      = 6'd4,
    G_UNALLOC_HINT = 6'd5,
    G_CLREX        = 6'd6,
    G_DSB          = 6'd7,
    G_DMB          = 6'd8,
    G_ISB          = 6'd9,
    G_SRS          = 6'd10,
    G_RFE          = 6'd11,
    G_MCRR         = 6'd12,
    G_MRRC         = 6'd13,
    G_STC          = 6'd14,
    G_MCR          = 6'd15,
    G_CDP          = 6'd16,
    G_MRC          = 6'd17,
    G_MRS_MSR      = 6'd18,
    G_CLZ          = 6'd19,
    G_BXJ          = 6'd20,
    G_SAT_ADDSUB   = 6'd21,
    G_BKPT         = 6'd22,
    G_SMC          = 6'd23,
    G_MOVW         = 6'd24,
    G_MOVT         = 6'd25,
    G_MSR_IMM      = 6'd26,
    G_HALF_MUL     = 6'd27,
    G_MUL          = 6'd28,
    G_SYNCH        = 6'd29,
    G_PAR_S        = 6'd30,
    G_PAR_U        = 6'd31,
    G_PACK         = 6'd32,
    G_USAD8        = 6'd33,
    G_USADA8       = 6'd34,
    G_SBFX         = 6'd35,
    G_BFC          = 6'd36,
    G_BFI          = 6'd37,
    G_UBFX         = 6'd38,
    G_VMRRC        = 6'd39,
    G_VSTM         = 6'd40,
    G_VLDM         = 6'd41,
    G_NEON64       = 6'd42,
    G_VFP_DP       = 6'd43,
    G_NEON_XFER    = 6'd44
  } grp_t;

  localparam logic [2:0] SzNone = 3'd0;
  localparam logic [2:0] SzByte = 3'd1;
  localparam logic [2:0] SzWord = 3'd4;

  typedef struct packed {
    logic       up;
    logic [2:0] sz;
    logic       ld;
    grp_t       grp;
    hclass_t    cls;
  } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/core/a32_instruction_class_decoder.sv =====
// ----------------------------------------------------------------------------
// a32_instruction_class_decoder
// Classifies one A32 instruction word per item by a priority-ordered decode
// tree and reports the handler class, group label and load/store attributes.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; an accepted item passes stage one, then the
// result register, where its result is offered until it is taken.
// Throughput: one item per cycle; the decode is a single pass of logic
// between the two registers, so nothing limits the rate but back-pressure.
// Reset: rst_n (synchronous, active low) empties both stages; no other state.
`default_nettype none

module a32_instruction_class_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: instruction [31:0]
  input  wire logic [a32icd_pkg::InstrWidth-1:0]   in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: handler_class [3:0], group_label [9:4], is_load [10],
  // access_bytes [13:11], unprivileged [14], zero [15]
  output logic [a32icd_pkg::OutTdataW-1:0]         out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready
);
  import a32icd_pkg::*;

  // --------------------------------------------------------------------------
  // Decode helpers. Each function mirrors one region of the decode tree and
  // returns a complete verdict; unused attribute fields are left at zero.
  // --------------------------------------------------------------------------
  function automatic verdict_t mk(hclass_t c);
    verdict_t v;
    v     = '0;
    v.cls = c;
    return v;
  endfunction

  function automatic verdict_t mk_grp(grp_t g);
    verdict_t v;
    v     = mk(C_OTHERS);
    v.grp = g;
    return v;
  endfunction

  // Hint, barrier, preload and Advanced SIMD space of the unconditional range.
  function automatic verdict_t hint_space(logic [31:0] w);
    logic [6:0] op1;
    logic [3:0] op2;
    logic [3:0] rn;
    verdict_t   v;
    op1 = w[26:20];
    op2 = w[7:4];
    rn  = w[19:16];
    if (op1 == 7'h10 && !op2[1] && !rn[0]) begin
      v = mk_grp(G_CPS);
    end else if (op1 == 7'h10 && op2 == 4'h0 && rn[0]) begin
      v = mk_grp(G_SETEND);
    end else if ((op1 & 7'h60) == 7'h20) begin
      v = mk_grp(G_NEON_DP);
    end else if ((op1 & 7'h71) == 7'h40) begin
      v = mk_grp(G_NEON_LS);
    end else if ((op1 & 7'h77) == 7'h41) begin
      v = mk_grp(G_UNALLOC_HINT);
    end else if ((op1 & 7'h77) == 7'h45) begin
      v = mk(C_PRELOAD);
    end else if ((op1 & 7'h77) == 7'h51) begin
      v = mk((rn != 4'hf) ? C_PRELOAD : C_UNPRED);
    end else if ((op1 & 7'h77) == 7'h55) begin
      v = mk(C_PRELOAD);
    end else if (op1 == 7'h57) begin
      case (op2)
        4'h1:    v = mk_grp(G_CLREX);
        4'h4:    v = mk_grp(G_DSB);
        4'h5:    v = mk_grp(G_DMB);
        4'h6:    v = mk_grp(G_ISB);
        default: v = mk(C_UNPRED);
      endcase
    end else if ((op1 & 7'h63) == 7'h43) begin
      v = mk(C_UNPRED);
    end else if (!op2[0]) begin
      // Register preload forms: op1 bit 3 does not take part.
      case (op1 & 7'h77)
        7'h61:                      v = mk_grp(G_UNALLOC_HINT);
        7'h65, 7'h71, 7'h75:        v = mk(C_PRELOAD_REG);
        7'h63, 7'h67, 7'h73, 7'h77: v = mk(C_UNPRED);
        default:                    v = mk(C_UNDEF);
      endcase
    end else begin
      v = mk(C_UNDEF);
    end
    return v;
  endfunction

  function automatic verdict_t uncond_space(logic [31:0] w);
    logic       rn_pc;
    logic [2:0] sub;
    verdict_t   v;
    rn_pc = (w[19:16] == 4'hf);
    sub   = w[23:21];
    if (!w[27]) begin
      v = hint_space(w);
    end else begin
      case ({w[26:24], w[20]})
        4'h0, 4'h2:             v = mk_grp(G_SRS);
        4'h1, 4'h3:             v = mk_grp(G_RFE);
        4'h4, 4'h5, 4'h6, 4'h7: v = mk(C_BRANCH);
        4'h8: begin
          if (sub == 3'd2)      v = mk_grp(G_MCRR);
          else if (sub == 3'd0) v = mk(C_UNDEF);
          else                  v = mk(C_COPRO_LS);
        end
        4'h9: begin
          if (sub == 3'd1 || sub == 3'd3) v = mk(rn_pc ? C_UNDEF : C_COPRO_LS);
          else if (sub == 3'd2)           v = mk_grp(G_MRRC);
          else if (sub[2])                v = mk(rn_pc ? C_COPRO_LS : C_UNDEF);
          else                            v = mk(C_UNDEF);
        end
        4'ha:    v = mk_grp(G_STC);
        4'hb:    v = mk(rn_pc ? C_COPRO_LS : C_UNDEF);
        4'hc:    v = mk_grp(w[4] ? G_MCR : G_CDP);
        4'hd:    v = mk_grp(w[4] ? G_MRC : G_CDP);
        default: v = mk(C_UNDEF);
      endcase
    end
    return v;
  endfunction

  function automatic verdict_t misc_space(logic [31:0] w);
    logic [2:0] op2;
    logic [1:0] op;
    verdict_t   v;
    op2 = w[6:4];
    op  = w[22:21];
    case (op2)
      3'h0: v = mk_grp(G_MRS_MSR);
      3'h1: begin
        if (op == 2'd1)      v = mk(C_BX_REG);
        else if (op == 2'd3) v = mk_grp(G_CLZ);
        else                 v = mk(C_UNDEF);
      end
      3'h2: v = (op == 2'd1) ? mk_grp(G_BXJ) : mk(C_UNDEF);
      3'h3: v = mk((op == 2'd1) ? C_BX_REG : C_UNDEF);
      3'h5: v = mk_grp(G_SAT_ADDSUB);
      3'h7: begin
        if (op == 2'd1)      v = mk_grp(G_BKPT);
        else if (op == 2'd3) v = mk_grp(G_SMC);
        else                 v = mk(C_UNDEF);
      end
      default: v = mk(C_UNDEF);
    endcase
    return v;
  endfunction

  function automatic verdict_t dp_space(logic [31:0] w);
    logic [4:0] op1;
    logic [3:0] op2;
    logic       ms;
    verdict_t   v;
    op1 = w[24:20];
    op2 = w[7:4];
    ms  = ((op1 & 5'h19) == 5'h10);
    if (w[25]) begin
      case (op1)
        5'h10:        v = mk_grp(G_MOVW);
        5'h14:        v = mk_grp(G_MOVT);
        5'h12, 5'h16: v = mk_grp(G_MSR_IMM);
        default:      v = mk(C_ALU_IMM);
      endcase
    end else if (!ms && !op2[0]) begin
      v = mk(C_ALU_REG);
    end else if (!ms && (op2 & 4'h9) == 4'h1) begin
      v = mk(C_ALU_SREG);
    end else if (ms && !op2[3]) begin
      v = misc_space(w);
    end else if (ms && (op2 & 4'h9) == 4'h8) begin
      v = mk_grp(G_HALF_MUL);
    end else if (!op1[4] && op2 == 4'h9) begin
      v = mk_grp(G_MUL);
    end else if (op1[4] && op2 == 4'h9) begin
      v = mk_grp(G_SYNCH);
    end else if (op2 == 4'hb || (op2 & 4'hd) == 4'hd) begin
      v    = mk(C_EXTRA_LS);
      v.up = ((op1 & 5'h12) == 5'h02);
    end else begin
      v = mk(C_NONE);
    end
    return v;
  endfunction

  function automatic verdict_t ldst_space(logic [31:0] w);
    logic [4:0] op1;
    verdict_t   v;
    op1 = w[24:20];
    if (w[25] && w[4]) begin
      v = mk(C_NONE);
    end else begin
      v    = mk(C_LDST);
      v.ld = op1[0];
      v.sz = op1[2] ? SzByte : SzWord;
      v.up = ((op1 & 5'h12) == 5'h02);
    end
    return v;
  endfunction

  function automatic verdict_t media_space(logic [31:0] w);
    logic [4:0] op1;
    verdict_t   v;
    op1 = w[24:20];
    if (op1 < 5'h04) begin
      v = mk_grp(G_PAR_S);
    end else if (op1 < 5'h08) begin
      v = mk_grp(G_PAR_U);
    end else if (op1 < 5'h10) begin
      v = mk_grp(G_PACK);
    end else begin
      case (op1)
        5'h18: begin
          if (w[7:5] != 3'd0) v = mk(C_UNDEF);
          else v = mk_grp((w[15:12] == 4'hf) ? G_USAD8 : G_USADA8);
        end
        5'h1a, 5'h1b: v = (w[6:5] == 2'd2) ? mk_grp(G_SBFX) : mk(C_UNDEF);
        5'h1c, 5'h1d: begin
          if (w[6:5] != 2'd0) v = mk(C_UNDEF);
          else v = mk_grp((w[3:0] == 4'hf) ? G_BFC : G_BFI);
        end
        5'h1e, 5'h1f: v = (w[6:5] == 2'd2) ? mk_grp(G_UBFX) : mk(C_UNDEF);
        // Unassigned media encodings have no handler.
        default:      v = mk(C_NONE);
      endcase
    end
    return v;
  endfunction

  function automatic verdict_t extreg_space(logic [31:0] w);
    verdict_t v;
    case (w[24:20])
      5'h04, 5'h05:                             v = mk_grp(G_VMRRC);
      5'h08, 5'h0a, 5'h0c, 5'h0e, 5'h12, 5'h16: v = mk_grp(G_VSTM);
      5'h09, 5'h0b, 5'h0d, 5'h0f, 5'h13, 5'h17: v = mk_grp(G_VLDM);
      5'h10, 5'h14, 5'h18, 5'h1c,
      5'h11, 5'h15, 5'h19, 5'h1d:               v = mk(C_COPRO_LS);
      default:                                  v = mk(C_NONE);
    endcase
    return v;
  endfunction

  function automatic verdict_t copro_space(logic [31:0] w);
    logic [5:0] op1;
    logic       op;
    logic       simd;
    logic       notlow;
    verdict_t   v;
    op1    = w[25:20];
    op     = w[4];
    simd   = (w[11:9] == 3'b101);
    notlow = ((op1 & 6'h3a) != 6'h00);
    if (!op1[5] && notlow && simd) begin
      v = extreg_space(w);
    end else if (!op1[5] && notlow && !simd) begin
      v = mk(C_COPRO_LS);
    end else if ((op1 & 6'h3e) == 6'h00) begin
      v = mk(C_UNDEF);
    end else if ((op1 & 6'h3e) == 6'h04 && simd) begin
      v = mk_grp(G_NEON64);
    end else if (op1 == 6'h04 && !simd) begin
      v = mk_grp(G_MCRR);
    end else if (op1 == 6'h05 && !simd) begin
      v = mk_grp(G_MRRC);
    end else if ((op1 & 6'h30) == 6'h20 && !op) begin
      v = mk_grp(simd ? G_VFP_DP : G_CDP);
    end else if ((op1 & 6'h30) == 6'h20 && op && simd) begin
      v = mk_grp(G_NEON_XFER);
    end else if ((op1 & 6'h31) == 6'h20 && op) begin
      v = mk_grp(G_MCR);
    end else if ((op1 & 6'h31) == 6'h21 && op) begin
      v = mk_grp(G_MRC);
    end else if ((op1 & 6'h30) == 6'h30) begin
      v = mk(C_SVC);
    end else begin
      v = mk(C_UNDEF);
    end
    return v;
  endfunction

  function automatic verdict_t classify(logic [31:0] w);
    verdict_t v;
    if (w[31:28] == 4'hf) begin
      v = uncond_space(w);
    end else begin
      case ({w[27:25], w[4]})
        4'h0, 4'h1, 4'h2, 4'h3: v = dp_space(w);
        4'h4, 4'h5, 4'h6:       v = ldst_space(w);
        4'h7:                   v = media_space(w);
        4'h8, 4'h9, 4'ha, 4'hb: v = mk(w[25] ? C_BRANCH : C_BLOCK);
        default:                v = copro_space(w);
      endcase
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Two-stage pipeline. Stage one holds the accepted instruction word; the
  // decode tree sits between it and the result register. Both stages move
  // together whenever the result register is free or is being emptied, so a
  // new item is taken in every cycle while the consumer keeps up, and a held
  // result does not block the input while stage one is empty.
  // --------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [InstrWidth-1:0] s1_instr_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  verdict_t              out_verdict_r;
  verdict_t              dec_verdict;
  logic                  out_free;
  logic                  s1_move;
  logic                  in_take;

  assign out_free = !out_valid_r || out_tready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_take  = in_tvalid && in_tready;

  always_comb begin
    dec_verdict = classify(s1_instr_r);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_instr_r <= in_tdata;
    end
    if (s1_move) begin
      out_verdict_r <= dec_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_verdict_r.up, out_verdict_r.sz, out_verdict_r.ld,
                       out_verdict_r.grp, out_verdict_r.cls};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A word held in stage one reaches the result register in the next cycle
  // whenever the result side is free.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("stage one advanced but no result appeared");

  // Access size is given exactly for word/byte load/store results.
  a_sz_only_ldst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_verdict_r.cls == C_LDST) == (out_verdict_r.sz != SzNone)))
    else $error("access size disagrees with handler class");

  // A group label is carried only by the others class.
  a_grp_only_others: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r.cls != C_OTHERS) |-> (out_verdict_r.grp == G_NIL))
    else $error("group label on a non-others result");

  // The unprivileged flag appears only on extra or word/byte load/store.
  a_up_only_ls: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r.up)
      |-> (out_verdict_r.cls == C_LDST || out_verdict_r.cls == C_EXTRA_LS))
    else $error("unprivileged flag on a non load/store result");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the A32 instruction class decoder. A directed set
// of instruction words covering every decode space and chosen corner cases is
// followed by random words steered towards the deeper parts of the tree. A
// local decode function predicts each verdict, and every result item is
// checked field by field against the oldest prediction, with random gaps on
// the input side and random back-pressure on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import a32icd_pkg::*;

  localparam int unsigned RandomWords = 1624;

  // A predicted verdict together with the word that produced it, so that a
  // mismatch report can name the instruction.
  typedef struct {
    logic [31:0] word;
    verdict_t    verdict;
  } decode_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  logic [31:0]   instr_backlog[$];
  decode_entry_t predicted_verdicts[$];
  int unsigned   mismatches = 0;
  int unsigned   issue_gap = 0;
  int unsigned   drain_stall = 0;
  bit            in_fired = 1'b0;
  bit            steady_run = 1'b0;

  a32_instruction_class_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic verdict_t classed(input hclass_t c, input grp_t g);
    verdict_t v;
    v.cls = c;
    v.grp = g;
    v.ld  = 1'b0;
    v.sz  = SzNone;
    v.up  = 1'b0;
    return v;
  endfunction

  // Walks the decode tree in priority order. The first test that matches in
  // each space wins, exactly as the hardware is meant to resolve overlaps.
  function automatic verdict_t decode_instruction(input logic [31:0] w);
    verdict_t   v;
    logic [6:0] hint_op1;
    logic [4:0] op1;
    logic [5:0] cop1;
    logic [3:0] op2;
    logic [3:0] rn;
    logic [2:0] sub;
    logic [1:0] misc_op;
    logic [3:0] uncond_sel;
    logic       rn_pc;
    logic       ms;
    logic       simd;
    logic       notlow;
    hint_op1   = w[26:20];
    op1        = w[24:20];
    cop1       = w[25:20];
    op2        = w[7:4];
    rn         = w[19:16];
    sub        = w[23:21];
    misc_op    = w[22:21];
    uncond_sel = {w[26:24], w[20]};
    rn_pc      = (rn == 4'hf);
    ms         = ((op1 & 5'h19) == 5'h10);
    simd       = (w[11:9] == 3'b101);
    notlow     = ((cop1 & 6'h3a) != 6'h00);
    v          = classed(C_NONE, G_NIL);

    if (w[31:28] == 4'hf) begin
      if (!w[27]) begin
        // Memory hints, barriers and the processor-state changes. CPS and
        // SETEND are split on the lowest bit of Rn.
        if (hint_op1 == 7'h10 && !op2[1] && !rn[0]) begin
          v = classed(C_OTHERS, G_CPS);
        end else if (hint_op1 == 7'h10 && op2 == 4'h0 && rn[0]) begin
          v = classed(C_OTHERS, G_SETEND);
        end else if ((hint_op1 & 7'h60) == 7'h20) begin
          v = classed(C_OTHERS, G_NEON_DP);
        end else if ((hint_op1 & 7'h71) == 7'h40) begin
          v = classed(C_OTHERS, G_NEON_LS);
        end else if ((hint_op1 & 7'h77) == 7'h41) begin
          v = classed(C_OTHERS, G_UNALLOC_HINT);
        end else if ((hint_op1 & 7'h77) == 7'h45) begin
          v = classed(C_PRELOAD, G_NIL);
        end else if ((hint_op1 & 7'h77) == 7'h51) begin
          v = classed(rn_pc ? C_UNPRED : C_PRELOAD, G_NIL);
        end else if ((hint_op1 & 7'h77) == 7'h55) begin
          v = classed(C_PRELOAD, G_NIL);
        end else if (hint_op1 == 7'h57) begin
          case (op2)
            4'h1:    v = classed(C_OTHERS, G_CLREX);
            4'h4:    v = classed(C_OTHERS, G_DSB);
            4'h5:    v = classed(C_OTHERS, G_DMB);
            4'h6:    v = classed(C_OTHERS, G_ISB);
            default: v = classed(C_UNPRED, G_NIL);
          endcase
        end else if ((hint_op1 & 7'h63) == 7'h43) begin
          v = classed(C_UNPRED, G_NIL);
        end else if (!op2[0]) begin
          // Register preloads ignore bit 3 of op1.
          case (hint_op1 & 7'h77)
            7'h61:                      v = classed(C_OTHERS, G_UNALLOC_HINT);
            7'h65, 7'h71, 7'h75:        v = classed(C_PRELOAD_REG, G_NIL);
            7'h63, 7'h67, 7'h73, 7'h77: v = classed(C_UNPRED, G_NIL);
            default:                    v = classed(C_UNDEF, G_NIL);
          endcase
        end else begin
          v = classed(C_UNDEF, G_NIL);
        end
      end else begin
        case (uncond_sel)
          4'h0, 4'h2:             v = classed(C_OTHERS, G_SRS);
          4'h1, 4'h3:             v = classed(C_OTHERS, G_RFE);
          4'h4, 4'h5, 4'h6, 4'h7: v = classed(C_BRANCH, G_NIL);
          4'h8: begin
            if (sub == 3'd2) v = classed(C_OTHERS, G_MCRR);
            else v = classed((sub == 3'd0) ? C_UNDEF : C_COPRO_LS, G_NIL);
          end
          4'h9: begin
            if (sub == 3'd1 || sub == 3'd3) v = classed(rn_pc ? C_UNDEF : C_COPRO_LS, G_NIL);
            else if (sub == 3'd2) v = classed(C_OTHERS, G_MRRC);
            else if (sub >= 3'd4) v = classed(rn_pc ? C_COPRO_LS : C_UNDEF, G_NIL);
            else v = classed(C_UNDEF, G_NIL);
          end
          4'ha:    v = classed(C_OTHERS, G_STC);
          4'hb:    v = classed(rn_pc ? C_COPRO_LS : C_UNDEF, G_NIL);
          4'hc:    v = classed(C_OTHERS, w[4] ? G_MCR : G_CDP);
          4'hd:    v = classed(C_OTHERS, w[4] ? G_MRC : G_CDP);
          default: v = classed(C_UNDEF, G_NIL);
        endcase
      end
    end else begin
      case ({w[27:25], w[4]})
        4'h0, 4'h1, 4'h2, 4'h3: begin
          // Data processing and the miscellaneous space.
          if (w[25]) begin
            case (op1)
              5'h10:        v = classed(C_OTHERS, G_MOVW);
              5'h14:        v = classed(C_OTHERS, G_MOVT);
              5'h12, 5'h16: v = classed(C_OTHERS, G_MSR_IMM);
              default:      v = classed(C_ALU_IMM, G_NIL);
            endcase
          end else if (!ms && !op2[0]) begin
            v = classed(C_ALU_REG, G_NIL);
          end else if (!ms && (op2 & 4'h9) == 4'h1) begin
            v = classed(C_ALU_SREG, G_NIL);
          end else if (ms && !op2[3]) begin
            case (op2[2:0])
              3'h0: v = classed(C_OTHERS, G_MRS_MSR);
              3'h1: begin
                if (misc_op == 2'd1) v = classed(C_BX_REG, G_NIL);
                else if (misc_op == 2'd3) v = classed(C_OTHERS, G_CLZ);
                else v = classed(C_UNDEF, G_NIL);
              end
              3'h2: v = (misc_op == 2'd1) ? classed(C_OTHERS, G_BXJ) : classed(C_UNDEF, G_NIL);
              3'h3: v = classed((misc_op == 2'd1) ? C_BX_REG : C_UNDEF, G_NIL);
              3'h5: v = classed(C_OTHERS, G_SAT_ADDSUB);
              3'h7: begin
                if (misc_op == 2'd1) v = classed(C_OTHERS, G_BKPT);
                else if (misc_op == 2'd3) v = classed(C_OTHERS, G_SMC);
                else v = classed(C_UNDEF, G_NIL);
              end
              default: v = classed(C_UNDEF, G_NIL);
            endcase
          end else if (ms && (op2 & 4'h9) == 4'h8) begin
            v = classed(C_OTHERS, G_HALF_MUL);
          end else if (!op1[4] && op2 == 4'h9) begin
            v = classed(C_OTHERS, G_MUL);
          end else if (op1[4] && op2 == 4'h9) begin
            v = classed(C_OTHERS, G_SYNCH);
          end else if (op2 == 4'hb || (op2 & 4'hd) == 4'hd) begin
            v    = classed(C_EXTRA_LS, G_NIL);
            v.up = ((op1 & 5'h12) == 5'h02);
          end
        end
        4'h4, 4'h5, 4'h6: begin
          if (!(w[25] && w[4])) begin
            v    = classed(C_LDST, G_NIL);
            v.ld = op1[0];
            v.sz = op1[2] ? SzByte : SzWord;
            v.up = ((op1 & 5'h12) == 5'h02);
          end
        end
        4'h7: begin
          // Media space; op1 values 0x10 to 0x17 and 0x19 are left unassigned.
          if (op1 < 5'h04) v = classed(C_OTHERS, G_PAR_S);
          else if (op1 < 5'h08) v = classed(C_OTHERS, G_PAR_U);
          else if (op1 < 5'h10) v = classed(C_OTHERS, G_PACK);
          else begin
            case (op1)
              5'h18: begin
                if (w[7:5] != 3'd0) v = classed(C_UNDEF, G_NIL);
                else v = classed(C_OTHERS, (w[15:12] == 4'hf) ? G_USAD8 : G_USADA8);
              end
              5'h1a, 5'h1b:
                v = (w[6:5] == 2'd2) ? classed(C_OTHERS, G_SBFX) : classed(C_UNDEF, G_NIL);
              5'h1c, 5'h1d: begin
                if (w[6:5] != 2'd0) v = classed(C_UNDEF, G_NIL);
                else v = classed(C_OTHERS, (w[3:0] == 4'hf) ? G_BFC : G_BFI);
              end
              5'h1e, 5'h1f:
                v = (w[6:5] == 2'd2) ? classed(C_OTHERS, G_UBFX) : classed(C_UNDEF, G_NIL);
              default: v = classed(C_NONE, G_NIL);
            endcase
          end
        end
        4'h8, 4'h9, 4'ha, 4'hb: v = classed(w[25] ? C_BRANCH : C_BLOCK, G_NIL);
        default: begin
          // Coprocessor space; coprocessors 10 and 11 are the extension
          // registers, everything else the generic coprocessor forms.
          if (!cop1[5] && notlow && simd) begin
            case (op1)
              5'h04, 5'h05: v = classed(C_OTHERS, G_VMRRC);
              5'h08, 5'h0a, 5'h0c, 5'h0e, 5'h12, 5'h16: v = classed(C_OTHERS, G_VSTM);
              5'h09, 5'h0b, 5'h0d, 5'h0f, 5'h13, 5'h17: v = classed(C_OTHERS, G_VLDM);
              5'h10, 5'h14, 5'h18, 5'h1c, 5'h11, 5'h15, 5'h19, 5'h1d:
                v = classed(C_COPRO_LS, G_NIL);
              default: v = classed(C_NONE, G_NIL);
            endcase
          end else if ((cop1 & 6'h21) == 6'h00 && notlow && !simd) begin
            v = classed(C_COPRO_LS, G_NIL);
          end else if ((cop1 & 6'h21) == 6'h01 && notlow && !simd) begin
            v = classed(C_COPRO_LS, G_NIL);
          end else if ((cop1 & 6'h3e) == 6'h00) begin
            v = classed(C_UNDEF, G_NIL);
          end else if ((cop1 & 6'h3e) == 6'h04 && simd) begin
            v = classed(C_OTHERS, G_NEON64);
          end else if (cop1 == 6'h04 && !simd) begin
            v = classed(C_OTHERS, G_MCRR);
          end else if (cop1 == 6'h05 && !simd) begin
            v = classed(C_OTHERS, G_MRRC);
          end else if ((cop1 & 6'h30) == 6'h20 && !w[4]) begin
            v = classed(C_OTHERS, simd ? G_VFP_DP : G_CDP);
          end else if ((cop1 & 6'h30) == 6'h20 && w[4] && simd) begin
            v = classed(C_OTHERS, G_NEON_XFER);
          end else if ((cop1 & 6'h31) == 6'h20 && w[4] && !simd) begin
            v = classed(C_OTHERS, G_MCR);
          end else if ((cop1 & 6'h31) == 6'h21 && w[4] && !simd) begin
            v = classed(C_OTHERS, G_MRC);
          end else if ((cop1 & 6'h30) == 6'h30) begin
            v = classed(C_SVC, G_NIL);
          end else begin
            v = classed(C_UNDEF, G_NIL);
          end
        end
      endcase
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Fully random words rarely reach the unconditional space or the narrow
  // media and coprocessor encodings, so most words are steered into one
  // space and keep random content elsewhere.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [3:0]  cond;
    w    = $urandom();
    cond = 4'($urandom_range(0, 14));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        w = w;
      end
      3, 4: begin
        w[31:28] = 4'hf;
      end
      5: begin
        w[31:27] = 5'b11110;
        if ($urandom_range(0, 1) == 0) w[26:20] = ($urandom_range(0, 1) == 0) ? 7'h57 : 7'h10;
        if ($urandom_range(0, 1) == 0) w[7:4] = 4'($urandom_range(0, 7));
      end
      6: begin
        w[31:28] = cond;
        w[27:26] = 2'b11;
        if ($urandom_range(0, 2) != 0) w[11:9] = 3'b101;
      end
      7: begin
        w[31:28] = cond;
        w[27:25] = 3'b011;
        w[4]     = 1'b1;
      end
      8: begin
        w[31:28] = cond;
        w[27:25] = 3'b000;
        w[24:23] = 2'b10;
        w[20]    = 1'b0;
        w[7]     = 1'b0;
      end
      default: begin
        w[31:28] = cond;
        w[27:25] = 3'b000;
        w[7]     = 1'b1;
        w[4]     = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one; none at all
  // during a steady stretch.
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got, input logic [31:0] word);
    if (got !== want) begin
      $display("%0d ns: %s mismatch for instruction %h: expected %0d, got %0d",
               $time, fname, word, want, got);
      mismatches++;
    end
  endtask

  // Driver: a new item is offered at the falling edge once the previous one
  // has been taken, after a random gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if ($urandom_range(0, 199) == 0) steady_run <= !steady_run;
      if (issue_gap > 0) begin
        in_tvalid <= 1'b0;
        issue_gap <= issue_gap - 1;
      end else if (instr_backlog.size() != 0) begin
        in_tdata  <= instr_backlog.pop_front();
        in_tvalid <= 1'b1;
        issue_gap <= next_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: ready drops for a random stretch now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (drain_stall > 0) begin
      out_tready  <= 1'b0;
      drain_stall <= drain_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) drain_stall <= next_gap();
    end
  end

  // Monitor: predictions are made as items are accepted, and each result
  // item is checked against the oldest one still waiting.
  always @(posedge clk) begin
    decode_entry_t head;
    in_fired = rst_n && in_tvalid && in_tready;
    if (in_fired) begin
      head.word    = in_tdata;
      head.verdict = decode_instruction(in_tdata);
      predicted_verdicts.push_back(head);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_verdicts.size() == 0) begin
        $display("%0d ns: result with none expected: expected nothing, got %h",
                 $time, out_tdata);
        mismatches++;
      end else begin
        head = predicted_verdicts.pop_front();
        report_field("handler_class", 8'(head.verdict.cls), 8'(out_tdata[3:0]), head.word);
        report_field("group_label", 8'(head.verdict.grp), 8'(out_tdata[9:4]), head.word);
        report_field("is_load", 8'(head.verdict.ld), 8'(out_tdata[10]), head.word);
        report_field("access_bytes", 8'(head.verdict.sz), 8'(out_tdata[13:11]), head.word);
        report_field("unprivileged", 8'(head.verdict.up), 8'(out_tdata[14]), head.word);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    // Directed words: the extremes, then one of each space and the corners
    // that the decode tree singles out.
    instr_backlog.push_back(32'h0000_0000);
    instr_backlog.push_back(32'hffff_ffff);
    instr_backlog.push_back(32'hf100_0000);   // CPS
    instr_backlog.push_back(32'hf101_0000);   // SETEND, told apart by Rn bit 0
    instr_backlog.push_back(32'hf57f_f01f);   // CLREX
    instr_backlog.push_back(32'hf57f_f04f);   // DSB
    instr_backlog.push_back(32'hf57f_f05f);   // DMB
    instr_backlog.push_back(32'hf57f_f06f);   // ISB
    instr_backlog.push_back(32'hf7d0_f000);   // register preload, op1 bit 3 masked
    instr_backlog.push_back(32'hf51f_f000);   // immediate preload with Rn as PC
    instr_backlog.push_back(32'hf5d0_f000);   // immediate preload
    instr_backlog.push_back(32'he700_0010);   // unassigned media op1 0x10
    instr_backlog.push_back(32'he790_0010);   // unassigned media op1 0x19
    instr_backlog.push_back(32'hee00_0a10);   // NEON 8/16/32-bit transfer
    instr_backlog.push_back(32'hee00_0e10);   // MCR on another coprocessor
    instr_backlog.push_back(32'hee10_0e10);   // MRC on another coprocessor
    instr_backlog.push_back(32'hec20_0a00);   // unassigned extension-register opcode
    instr_backlog.push_back(32'hef00_0000);   // SVC
    instr_backlog.push_back(32'he590_0000);   // LDR word
    instr_backlog.push_back(32'he4f0_0000);   // LDRBT, unprivileged byte load
    instr_backlog.push_back(32'hea00_0000);   // B
    instr_backlog.push_back(32'he890_0000);   // LDM
    instr_backlog.push_back(32'he12f_ff10);   // BX
    instr_backlog.push_back(32'he000_0090);   // MUL
    instr_backlog.push_back(32'he0f0_00b0);   // LDRHT, unprivileged extra load
    instr_backlog.push_back(32'he280_0000);   // ALU immediate
    repeat (RandomWords) instr_backlog.push_back(random_instruction());

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    wait (instr_backlog.size() == 0 && !in_tvalid);
    wait (predicted_verdicts.size() == 0);
    // Two register stages: the extra wait shows up any stray result.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("a32_instruction_class_decoder verification clean");
    end else begin
      $display("a32_instruction_class_decoder verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("a32_instruction_class_decoder verification failed");
    $finish;
  end

endmodule

`default_nettype wire
